>>> design/assert_macros.svh
// Assertion macros shared by the recent item list RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> design/rimru_pkg.sv
// Types and constants of the recent item list
`timescale 1ns / 1ps
package rimru_pkg;
  localparam int CAP    = 16;
  localparam int IW     = $clog2(CAP);
  localparam int CW     = $clog2(CAP + 1);
  localparam int KEY_W  = 32;
  localparam int REF_W  = 16;
  localparam int MAX_W  = 5;
  localparam int LW     = (CW > MAX_W) ? CW : MAX_W;
  localparam int SLOT_W = KEY_W + REF_W;

  typedef enum logic [1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_BACK  = 2'd1,
    OP_SEARCH    = 2'd2,
    OP_REMOVE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_CMP  = 2'd2,
    S_UPD  = 2'd3
  } state_e;

  // Order list update request
  typedef struct packed {
    logic          valid;
    op_e           op;
    logic          hit;
    logic [IW-1:0] hpos;
    logic          full;
  } upd_t;
endpackage

>>> design/rimru_ram.sv
// Generic single write port RAM with registered read
`timescale 1ns / 1ps
module rimru_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> design/rimru_order.sv
// Order list: physical slot pointers, newest first, and the entry count
`timescale 1ns / 1ps
module rimru_order (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rimru_pkg::upd_t         upd_i,
  input  logic [rimru_pkg::IW-1:0] pos_i,
  output logic [rimru_pkg::IW-1:0] rd_slot_o,
  output logic [rimru_pkg::IW-1:0] wr_slot_o,
  output logic [rimru_pkg::CW-1:0] cnt_o,
  output logic [rimru_pkg::CW-1:0] cnt_next_o
);
  import rimru_pkg::*;

  logic [IW-1:0] ord_q [CAP];
  logic [IW-1:0] ord_d [CAP];
  logic [CW-1:0] cnt_q, cnt_d, c2;
  logic [IW-1:0] alloc;

  assign rd_slot_o  = ord_q[pos_i];
  assign cnt_o      = cnt_q;
  assign cnt_next_o = cnt_d;
  assign wr_slot_o  = alloc;

  // Pointer permutation update
  always_comb begin
    for (int i = 0; i < CAP; i++) begin
      ord_d[i] = ord_q[i];
    end
    cnt_d = cnt_q;
    c2    = upd_i.full ? cnt_q - CW'(1) : cnt_q;
    alloc = ord_q[c2[IW-1:0]];
    if (upd_i.op == OP_INS_BACK) begin
      alloc = upd_i.full ? ord_q[0] : ord_q[cnt_q[IW-1:0]];
    end
    if (upd_i.valid) begin
      case (upd_i.op)
        OP_INS_FRONT: begin
          if (upd_i.hit) begin
            for (int i = 1; i < CAP; i++) begin
              if (IW'(i) <= upd_i.hpos) ord_d[i] = ord_q[IW'(i - 1)];
            end
            ord_d[0] = ord_q[upd_i.hpos];
          end else begin
            for (int i = 1; i < CAP; i++) begin
              if (CW'(i) <= c2) ord_d[i] = ord_q[IW'(i - 1)];
            end
            ord_d[0] = alloc;
            cnt_d    = c2 + CW'(1);
          end
        end
        OP_INS_BACK: begin
          if (upd_i.full) begin
            for (int i = 0; i < CAP; i++) begin
              if (CW'(i) + CW'(1) < cnt_q) ord_d[i] = ord_q[IW'(i + 1)];
              else if (CW'(i) + CW'(1) == cnt_q) ord_d[i] = alloc;
            end
          end else begin
            cnt_d = cnt_q + CW'(1);
          end
        end
        OP_REMOVE: begin
          if (upd_i.hit) begin
            for (int i = 0; i < CAP; i++) begin
              if (IW'(i) >= upd_i.hpos && CW'(i) + CW'(1) < cnt_q) begin
                ord_d[i] = ord_q[IW'(i + 1)];
              end else if (CW'(i) + CW'(1) == cnt_q) begin
                ord_d[i] = ord_q[upd_i.hpos];
              end
            end
            cnt_d = cnt_q - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAP; i++) ord_q[i] <= IW'(i);
      cnt_q <= '0;
    end else begin
      for (int i = 0; i < CAP; i++) ord_q[i] <= ord_d[i];
      cnt_q <= cnt_d;
    end
  end
endmodule

>>> design/recent_item_mru_list.sv
// Per item: accept in idle, a read and a compare step per entry compared until a hit
// or the last entry (no scan when empty), then the update state. One item at a time:
// a new item is accepted only back in idle. The slot RAM (registered read) is read in
// each read step; the update cycle waits while an earlier result is held unaccepted.
// Reset: list empty, slot pointers in order, max_entries = 16; slot RAM is not
// cleared since only slots below the count are ever read.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module recent_item_mru_list (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,     // max_entries
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // word_key[31:0], entry_ref[47:32]
  input  logic [1:0]  s_axis_tuser_i,  // op[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // found[0], found_ref[16:1], entry_count[21:17]
);
  import rimru_pkg::*;

  state_e            state_q, state_d;
  logic [MAX_W-1:0]  max_q;
  op_e               op_q;
  logic [KEY_W-1:0]  key_q;
  logic [REF_W-1:0]  ref_q, href_q;
  logic [IW-1:0]     pos_q, hpos_q;
  logic              hit_q;
  logic              out_valid_q;
  logic [23:0]       out_data_q;
  logic              in_acc, key_match, last_pos, out_free;
  logic [LW-1:0]     lim;
  upd_t              upd;
  logic [IW-1:0]     rd_slot, wr_slot;
  logic [CW-1:0]     cnt, cnt_next;
  logic              ram_we;
  logic [SLOT_W-1:0] rdata;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign key_match       = rdata[KEY_W-1:0] == key_q;
  assign last_pos        = CW'(pos_q) + CW'(1) == cnt;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Effective limit, clamped to 1..CAP
  always_comb begin
    lim = LW'(max_q);
    if (max_q == '0) lim = LW'(1);
    else if (LW'(max_q) > LW'(CAP)) lim = LW'(CAP);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = (cnt == '0) ? S_UPD : S_READ;
      S_READ: state_d = S_CMP;
      S_CMP:  state_d = (key_match || last_pos) ? S_UPD : S_READ;
      S_UPD:  state_d = out_free ? S_IDLE : S_UPD;
      default: state_d = S_IDLE;
    endcase
  end

  // Update request and slot write
  always_comb begin
    upd.valid = (state_q == S_UPD) && out_free;
    upd.op    = op_q;
    upd.hit   = hit_q;
    upd.hpos  = hpos_q;
    upd.full  = (LW'(cnt) >= lim) && (cnt != '0);
    ram_we    = upd.valid &&
                ((op_q == OP_INS_FRONT && !hit_q) || op_q == OP_INS_BACK);
  end

  rimru_order u_order (
    .clk_i,
    .rst_ni,
    .upd_i      (upd),
    .pos_i      (pos_q),
    .rd_slot_o  (rd_slot),
    .wr_slot_o  (wr_slot),
    .cnt_o      (cnt),
    .cnt_next_o (cnt_next)
  );

  rimru_ram #(.Width(SLOT_W), .Depth(CAP)) u_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (wr_slot),
    .wdata_i ({ref_q, key_q}),
    .raddr_i (rd_slot),
    .rdata_o (rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      max_q       <= MAX_W'(16);
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      pos_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) max_q <= cfg_wdata_i;
      if (upd.valid) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
      if (in_acc) begin
        hit_q <= 1'b0;
        pos_q <= '0;
      end else if (state_q == S_CMP) begin
        if (key_match) hit_q <= 1'b1;
        else pos_q <= pos_q + IW'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= op_e'(s_axis_tuser_i);
      key_q <= s_axis_tdata_i[31:0];
      ref_q <= s_axis_tdata_i[47:32];
    end
    if (state_q == S_CMP && key_match) begin
      hpos_q <= pos_q;
      href_q <= rdata[SLOT_W-1:KEY_W];
    end
    if (upd.valid) begin
      out_data_q <= {2'b00, 5'(cnt_next), hit_q ? href_q : 16'd0, hit_q};
    end
  end

  `ASSERT_NEVER(a_cnt_cap, cnt > CW'(CAP), "entry count above capacity")
  `ASSERT_CLK(a_upd_out, state_q == S_UPD |=> out_valid_q, "no result after update")
  `ASSERT_CLK(a_hit_upd, state_q == S_CMP && key_match |=> state_q == S_UPD,
              "hit did not end scan")
  `ASSERT_CLK(a_out_hold, out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(out_data_q),
              "pending result changed")
endmodule

>>> verif/tb.sv
// Testbench for the recent item list: directed and random items, checked against a predictor
`timescale 1ns / 1ps
module tb;
  import rimru_pkg::*;

  localparam int MAXC = 16;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;   // word_key[31:0], entry_ref[47:32]
  logic [1:0]  s_axis_tuser_i = '0;   // op[1:0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;        // found[0], found_ref[16:1], entry_count[21:17]

  recent_item_mru_list i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // packed from the top bit down, so found sits in bit 0
  typedef struct packed {
    logic [4:0]  entry_count;
    logic [15:0] found_ref;
    logic        found;
  } lookup_res_t;

  // predictor state
  logic [31:0] list_keys[MAXC];
  logic [15:0] list_refs[MAXC];
  int          list_len;
  logic [4:0]  max_entries_q;
  lookup_res_t expected_q[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit recv_hold = 1'b0;

  // reference behavior of one operation
  function automatic lookup_res_t predict_op(op_e op, logic [31:0] key, logic [15:0] rf);
    lookup_res_t r;
    int lim, pos, i;
    logic [15:0] href;
    lim = (max_entries_q == 0) ? 1 : (max_entries_q > MAXC ? MAXC : max_entries_q);
    pos = -1;
    href = '0;
    for (i = 0; i < list_len; i++) begin
      if (pos < 0 && list_keys[i] == key) begin
        pos = i;
        href = list_refs[i];
      end
    end
    case (op)
      OP_INS_FRONT: begin
        if (pos >= 0) begin
          for (i = pos; i > 0; i--) begin
            list_keys[i] = list_keys[i-1];
            list_refs[i] = list_refs[i-1];
          end
          list_refs[0] = href;
        end else begin
          if (list_len >= lim && list_len > 0) list_len--;
          for (i = list_len; i > 0; i--) begin
            list_keys[i] = list_keys[i-1];
            list_refs[i] = list_refs[i-1];
          end
          list_refs[0] = rf;
          list_len++;
        end
        list_keys[0] = key;
      end
      OP_INS_BACK: begin
        if (list_len >= lim && list_len > 0) begin
          for (i = 0; i + 1 < list_len; i++) begin
            list_keys[i] = list_keys[i+1];
            list_refs[i] = list_refs[i+1];
          end
          list_len--;
        end
        list_keys[list_len] = key;
        list_refs[list_len] = rf;
        list_len++;
      end
      OP_REMOVE: begin
        if (pos >= 0) begin
          for (i = pos; i + 1 < list_len; i++) begin
            list_keys[i] = list_keys[i+1];
            list_refs[i] = list_refs[i+1];
          end
          list_len--;
        end
      end
      default: ;
    endcase
    r.found = (pos >= 0);
    r.found_ref = href;
    r.entry_count = list_len[4:0];
    return r;
  endfunction

  // send one item, predict its result at acceptance; valid stays up for the
  // next call, which drops it while idling
  task automatic send_item(op_e op, logic [31:0] key, logic [15:0] rf);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {rf, key};
    s_axis_tuser_i  <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_q.push_back(predict_op(op, key, rf));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [4:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    max_entries_q = v;
  endtask

  // receiver stall pattern
  always @(negedge clk_i) begin
    m_axis_tready_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    lookup_res_t got, exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[21:0];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.found !== exp_r.found)
          $display("%0t: found exp %0d got %0d", $time, exp_r.found, got.found);
        if (got.found_ref !== exp_r.found_ref)
          $display("%0t: found_ref exp %h got %h", $time, exp_r.found_ref, got.found_ref);
        if (got.entry_count !== exp_r.entry_count)
          $display("%0t: entry_count exp %0d got %0d", $time, exp_r.entry_count,
                   got.entry_count);
        if (got !== exp_r) errors++;
      end
    end
  end

  // random key from a small pool, so hits are frequent
  function automatic logic [31:0] pick_key();
    if ($urandom_range(9) == 0) return $urandom();
    return 32'h5A5A_0000 | $urandom_range(23);
  endfunction

  task automatic test_directed();
    send_item(OP_SEARCH, 32'h0, 16'h0);           // empty list
    send_item(OP_REMOVE, 32'hFFFF_FFFF, 16'h0);
    send_item(OP_INS_FRONT, 32'h0, 16'hFFFF);
    send_item(OP_INS_FRONT, 32'hFFFF_FFFF, 16'h0);
    send_item(OP_INS_BACK, 32'h1234_5678, 16'hA5A5);
    send_item(OP_INS_BACK, 32'h0, 16'h5A5A);      // duplicate at back
    send_item(OP_INS_FRONT, 32'h0, 16'h1111);      // hit keeps old ref
    send_item(OP_SEARCH, 32'hFFFF_FFFF, 16'h0);
    send_item(OP_REMOVE, 32'h0, 16'h0);
    send_item(OP_SEARCH, 32'h0, 16'h0);
    send_item(OP_REMOVE, 32'hDEAD_BEEF, 16'h0);    // remove miss
    for (int i = 0; i < 18; i++) send_item(OP_INS_FRONT, 32'h100 + i, 16'(i));
  endtask

  task automatic test_limits();
    write_limit(5'd0);                              // acts as one
    send_item(OP_INS_BACK, 32'h7, 16'h7);
    send_item(OP_INS_FRONT, 32'h8, 16'h8);
    write_limit(5'd31);                             // clamps to capacity
    for (int i = 0; i < 18; i++) send_item(OP_INS_BACK, 32'h200 + i, 16'(i));
    write_limit(5'd3);                              // below count
    send_item(OP_INS_FRONT, 32'h300, 16'h1);
    send_item(OP_INS_BACK, 32'h301, 16'h2);
    send_item(OP_INS_FRONT, 32'h301, 16'h3);
  endtask

  task automatic test_random(int n);
    op_e op;
    for (int i = 0; i < n; i++) begin
      op = op_e'($urandom_range(3));
      send_item(op, pick_key(), 16'($urandom()));
    end
  endtask

  // receiver holds off long while items keep coming
  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (400) @(negedge clk_i);
        recv_hold = 1'b0;
      end
      test_random(20);
    join
  endtask

  initial begin
    list_len = 0;
    max_entries_q = 5'd16;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_idle_pct = 35; recv_idle_pct = 73;
    test_directed();
    test_limits();
    write_limit(5'd16);
    test_random(170);
    send_idle_pct = 73; recv_idle_pct = 35;
    write_limit(5'd6);
    test_random(130);
    write_limit(5'd1);
    test_random(30);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_limit(5'd12);
    test_backpressure();
    test_random(130);
    wait_drained();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule

>>> sim.f
+incdir+design
design/rimru_pkg.sv
design/rimru_ram.sv
design/rimru_order.sv
design/recent_item_mru_list.sv
verif/tb.sv
